/* rtl/rbb_pkg.sv */
// ----------------------------------------------------------------------------
// rbb_pkg
// Shared types and constants for the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
package rbb_pkg;

  localparam int MaxWidth   = 1024;
  localparam int MaxHeight  = 1024;
  localparam int COL_W      = $clog2(MaxWidth);
  localparam int ROW_W      = $clog2(MaxHeight);
  localparam int DIM_W      = 11;
  localparam int FifoDepth  = 4;
  localparam int FIFO_AW    = $clog2(FifoDepth);
  localparam int FIFO_CW    = $clog2(FifoDepth + 1);
  localparam int SUM_W      = 12;
  localparam int RECIP_W    = 14;
  localparam int RECIP_SH   = 16;

  // Reciprocals of 9 and 6, scaled by 2^16, exact for sums below 2^SUM_W
  localparam logic [RECIP_W-1:0] RECIP_9 = 14'd7282;
  localparam logic [RECIP_W-1:0] RECIP_6 = 14'd10923;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd480;
  localparam logic [DIM_W-1:0] DIM_MIN    = 11'd2;

  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    DIV_4,
    DIV_6,
    DIV_9
  } div_sel_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       frame_end;
  } out_beat_t;

  // One window column plus whether the centre is emitted after the shift
  typedef struct packed {
    logic        emit;
    logic [23:0] top;
    logic [23:0] mid;
    logic [23:0] bot;
  } col_tok_t;

  typedef struct packed {
    logic draining;
    logic pos_zero;
  } front_stat_t;

endpackage

/* rtl/rgb_box_blur_3x3_top.sv */
// Path: the beat that completes a window passes the line store read, the column queue, the
// window, the sum and output registers; it arrives one row plus one pixel after the centre pixel.
// Throughput: one beat per cycle while the column queue has room and the output is not stalled.
// Frame tail: width+1 flush beats drain the last results of a frame.
// Reset: synchronous active-low; sizes return to 640x480, counters and window
// clear; line store contents are undefined until written.
// ----------------------------------------------------------------------------
// rgb_box_blur_3x3_top
// 3x3 RGB box blur over a raster pixel stream with rounded mean per channel.
// ----------------------------------------------------------------------------
module rgb_box_blur_3x3_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  rbb_pkg::in_beat_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rbb_pkg::out_beat_t        out_data,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [rbb_pkg::DIM_W-1:0] cfg_wdata
);
  import rbb_pkg::*;

  logic [DIM_W-1:0]   width_r, height_r, width_c, height_c;
  logic               restart, push, pop, fifo_empty;
  col_tok_t           push_data, pop_data;
  logic [FIFO_CW-1:0] fifo_count;
  front_stat_t        stat;

  assign restart = cfg_we && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT);

  // Hold frame size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  width_r  <= cfg_wdata;
        CFG_FRAME_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp sizes to the supported range
  always_comb begin
    width_c  = (width_r < DIM_MIN) ? DIM_MIN :
               (width_r > DIM_W'(MaxWidth)) ? DIM_W'(MaxWidth) : width_r;
    height_c = (height_r < DIM_MIN) ? DIM_MIN :
               (height_r > DIM_W'(MaxHeight)) ? DIM_W'(MaxHeight) : height_r;
  end

  rbb_front u_front (
    .clk(clk), .rst_n(rst_n), .restart(restart),
    .width(width_c), .height(height_c),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .fifo_count(fifo_count), .push(push), .push_data(push_data), .stat(stat)
  );

  rbb_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .restart(restart),
    .push(push), .push_data(push_data), .pop(pop), .pop_data(pop_data),
    .empty(fifo_empty), .count(fifo_count)
  );

  rbb_back u_back (
    .clk(clk), .rst_n(rst_n), .restart(restart),
    .width(width_c), .height(height_c),
    .fifo_empty(fifo_empty), .pop_data(pop_data), .pop(pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && fifo_count == FIFO_CW'(FifoDepth)))
    else $error("column queue overflow");

  a_drain_at_origin: assert property (@(posedge clk) disable iff (!rst_n)
    stat.draining |-> stat.pos_zero)
    else $error("drain pending away from frame origin");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !fifo_empty)
    else $error("pop from empty queue");
`endif

endmodule

/* rtl/rbb_front.sv */
// ----------------------------------------------------------------------------
// rbb_front
// Classifies beats, tracks input position and drain count, owns line stores.
// ----------------------------------------------------------------------------
module rbb_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       restart,
  input  logic [rbb_pkg::DIM_W-1:0]  width,
  input  logic [rbb_pkg::DIM_W-1:0]  height,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  rbb_pkg::in_beat_t          in_data,
  input  logic [rbb_pkg::FIFO_CW-1:0] fifo_count,
  output logic                       push,
  output rbb_pkg::col_tok_t          push_data,
  output rbb_pkg::front_stat_t       stat
);
  import rbb_pkg::*;

  logic [23:0] upper_mem [MaxWidth];
  logic [23:0] lower_mem [MaxWidth];

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] pend_r, pend_nxt;

  logic             s1_vld_r, s1_pix_r, s1_kval_r, s1_emit_r;
  logic [COL_W-1:0] s1_col_r;
  logic [23:0]      s1_bot_r;
  logic [23:0]      rd_up_r, rd_lo_r;

  logic             acc, do_pix, do_flush, issue, pix_emit, kval;
  logic [DIM_W-1:0] k;
  logic [COL_W-1:0] rd_addr;
  logic [23:0]      pix;

  // Credit check: queue slots left for everything in flight
  assign in_ready = ({1'b0, fifo_count} + {{FIFO_CW{1'b0}}, s1_vld_r})
                    < (FIFO_CW + 1)'(FifoDepth);
  assign acc      = in_valid && in_ready;
  assign pix      = {in_data.in_red, in_data.in_green, in_data.in_blue};

  // Classify and step the position counters
  always_comb begin
    do_pix   = acc && (in_data.req_type == REQ_PIXEL) && (pend_r == '0);
    do_flush = acc && (in_data.req_type == REQ_FLUSH) && (pend_r != '0);
    issue    = do_pix || do_flush;
    pix_emit = ((row_r != '0) && (col_r != '0)) || (row_r > ROW_W'(1));
    k        = width + DIM_W'(1) - pend_r;
    kval     = k < width;
    rd_addr  = do_pix ? col_r : k[COL_W-1:0];
    col_nxt  = col_r;
    row_nxt  = row_r;
    pend_nxt = pend_r;
    if (do_flush) begin
      pend_nxt = pend_r - DIM_W'(1);
    end else if (do_pix) begin
      if (({1'b0, row_r} + 1'b1 >= height) && ({1'b0, col_r} + 1'b1 >= width)) begin
        col_nxt  = '0;
        row_nxt  = '0;
        pend_nxt = width + DIM_W'(1);
      end else if ({1'b0, col_r} + 1'b1 >= width) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r    <= '0;
      row_r    <= '0;
      pend_r   <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      pend_r   <= pend_nxt;
      s1_vld_r <= issue;
    end
  end

  // Track the issued beat while its line store read completes
  always_ff @(posedge clk) begin
    s1_pix_r  <= do_pix;
    s1_kval_r <= kval;
    s1_emit_r <= do_flush || pix_emit;
    s1_col_r  <= col_r;
    s1_bot_r  <= pix;
  end

  // Line stores: lower written with the new pixel, upper with the old lower
  always_ff @(posedge clk) begin
    rd_up_r <= upper_mem[rd_addr];
    rd_lo_r <= lower_mem[rd_addr];
    if (do_pix) begin
      lower_mem[col_r] <= pix;
    end
    if (s1_vld_r && s1_pix_r) begin
      upper_mem[s1_col_r] <= rd_lo_r;
    end
  end

  // Form the window column
  always_comb begin
    push           = s1_vld_r;
    push_data.emit = s1_emit_r;
    push_data.top  = (s1_pix_r || s1_kval_r) ? rd_up_r : '0;
    push_data.mid  = (s1_pix_r || s1_kval_r) ? rd_lo_r : '0;
    push_data.bot  = s1_pix_r ? s1_bot_r : '0;
  end

  assign stat.draining = pend_r != '0;
  assign stat.pos_zero = (col_r == '0) && (row_r == '0);

endmodule

/* rtl/rbb_fifo.sv */
// ----------------------------------------------------------------------------
// rbb_fifo
// Short queue of window columns between the front and back parts.
// ----------------------------------------------------------------------------
module rbb_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        restart,
  input  logic                        push,
  input  rbb_pkg::col_tok_t           push_data,
  input  logic                        pop,
  output rbb_pkg::col_tok_t           pop_data,
  output logic                        empty,
  output logic [rbb_pkg::FIFO_CW-1:0] count
);
  import rbb_pkg::*;

  col_tok_t           slot_r [FifoDepth];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_CW-1:0] cnt_r;

  assign empty    = cnt_r == '0;
  assign count    = cnt_r;
  assign pop_data = slot_r[rp_r];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + FIFO_AW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + FIFO_AW'(1);
      end
      cnt_r <= cnt_r + FIFO_CW'(push) - FIFO_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end

endmodule

/* rtl/rbb_back.sv */
// ----------------------------------------------------------------------------
// rbb_back
// Shifts the 3x3 window, sums in-image cells and divides into the result.
// ----------------------------------------------------------------------------
module rbb_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      restart,
  input  logic [rbb_pkg::DIM_W-1:0] width,
  input  logic [rbb_pkg::DIM_W-1:0] height,
  input  logic                      fifo_empty,
  input  rbb_pkg::col_tok_t         pop_data,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rbb_pkg::out_beat_t        out_data
);
  import rbb_pkg::*;

  logic [23:0]      win_r [9];
  logic             win_emit_r, b_vld_r, out_vld_r;
  logic [COL_W-1:0] ocol_r;
  logic [ROW_W-1:0] orow_r;
  logic [SUM_W-1:0] bsum_r [3];
  div_sel_t         bdiv_r;
  logic             bend_r;
  out_beat_t        out_r;

  logic             adv, cap;
  logic             rlo, rhi, clo, chi, last_col, last_row;
  logic [SUM_W-1:0] sum [3];
  logic [SUM_W-1:0] half;
  div_sel_t         div_sel;
  logic [7:0]       quo [3];
  logic [SUM_W+RECIP_W-1:0] prod [3];

  assign adv = !out_vld_r || out_ready;
  assign pop = adv && !fifo_empty;
  assign cap = adv && win_emit_r;

  // Shift a column into the window
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (pop) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r*3+0] <= win_r[r*3+1];
        win_r[r*3+1] <= win_r[r*3+2];
      end
      win_r[2] <= pop_data.top;
      win_r[5] <= pop_data.mid;
      win_r[8] <= pop_data.bot;
    end
  end

  // Sum the in-image cells and pick the divisor
  always_comb begin
    rlo      = orow_r != '0;
    rhi      = ({1'b0, orow_r} + 1'b1) < height;
    clo      = ocol_r != '0;
    chi      = ({1'b0, ocol_r} + 1'b1) < width;
    last_row = !rhi;
    last_col = !chi;
    if ((rlo && rhi) && (clo && chi)) begin
      div_sel = DIV_9;
      half    = SUM_W'(4);
    end else if ((rlo && rhi) || (clo && chi)) begin
      div_sel = DIV_6;
      half    = SUM_W'(3);
    end else begin
      div_sel = DIV_4;
      half    = SUM_W'(2);
    end
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = half;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if ((r != 0 || rlo) && (r != 2 || rhi) && (c != 0 || clo) && (c != 2 || chi)) begin
            sum[ch] = sum[ch] + SUM_W'(win_r[r*3+c][8*ch +: 8]);
          end
        end
      end
    end
  end

  // Register sums and step the output position
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      win_emit_r <= 1'b0;
      b_vld_r    <= 1'b0;
      out_vld_r  <= 1'b0;
      ocol_r     <= '0;
      orow_r     <= '0;
    end else begin
      if (pop) begin
        win_emit_r <= pop_data.emit;
      end else if (adv) begin
        win_emit_r <= 1'b0;
      end
      if (adv) begin
        b_vld_r   <= win_emit_r;
        out_vld_r <= b_vld_r;
      end
      if (cap) begin
        if (last_col) begin
          ocol_r <= '0;
          orow_r <= last_row ? '0 : orow_r + ROW_W'(1);
        end else begin
          ocol_r <= ocol_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cap) begin
      bsum_r <= sum;
      bdiv_r <= div_sel;
      bend_r <= last_row && last_col;
    end
  end

  // Divide by the cell count with a reciprocal multiply, or a shift for four cells
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      case (bdiv_r)
        DIV_9: begin
          prod[ch] = bsum_r[ch] * RECIP_9;
          quo[ch]  = prod[ch][RECIP_SH +: 8];
        end
        DIV_6: begin
          prod[ch] = bsum_r[ch] * RECIP_6;
          quo[ch]  = prod[ch][RECIP_SH +: 8];
        end
        default: begin
          prod[ch] = '0;
          quo[ch]  = bsum_r[ch][9:2];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv && b_vld_r) begin
      out_r.out_blue  <= quo[0];
      out_r.out_green <= quo[1];
      out_r.out_red   <= quo[2];
      out_r.frame_end <= bend_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
